### rtl/gtex_pkg.sv
// Shared types and constants for the grid block texture interpolator.
// No dependencies; gen, interp, top and testbench use its scoped names.
package gtex_pkg;

    localparam int ACC_W      = 10;   // per-column corner interpolants
    localparam int DLT_W      = 6;    // corner deltas, (b - a) >>> 3
    localparam int DIF_W      = 8;    // row deltas, (s2 - s1) >>> 3
    localparam int SUM_W      = 12;   // sampled u, v and shade sum
    localparam int ADDR_MAX_W = 16;   // widest texture address carried

    localparam logic [7:0] TEXEL_BIAS = 8'd224;
    localparam logic [2:0] LAST_COL   = 3'd7;
    localparam logic [1:0] LAST_ROW   = 2'd3;   // row pair index of row 6

    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_BLOCK = 1'b1
    } t_kind;

    // generator -> interpolation
    typedef struct packed {
        t_kind                   kind;
        logic [2:0]              x;
        logic [1:0]              yi;
        logic                    last;
        logic [ADDR_MAX_W-1:0]   waddr;
        logic [7:0]              wdata;
        logic signed [ACC_W-1:0] s1;
        logic signed [ACC_W-1:0] s2;
        logic signed [ACC_W-1:0] t1;
        logic signed [ACC_W-1:0] t2;
        logic signed [ACC_W-1:0] z1;
        logic signed [ACC_W-1:0] z2;
    } t_item;

    // row delta stage
    typedef struct packed {
        t_kind                   kind;
        logic [2:0]              x;
        logic [1:0]              yi;
        logic                    last;
        logic [ADDR_MAX_W-1:0]   waddr;
        logic [7:0]              wdata;
        logic signed [ACC_W-1:0] s1;
        logic signed [ACC_W-1:0] t1;
        logic signed [ACC_W-1:0] z1;
        logic signed [DIF_W-1:0] ds;
        logic signed [DIF_W-1:0] dt;
        logic signed [DIF_W-1:0] dz;
    } t_mid;

    // sample stage, drives the texture port
    typedef struct packed {
        t_kind                   kind;
        logic [2:0]              x;
        logic [1:0]              yi;
        logic                    last;
        logic [ADDR_MAX_W-1:0]   waddr;
        logic [7:0]              wdata;
        logic signed [SUM_W-1:0] u;
        logic signed [SUM_W-1:0] v;
        logic signed [SUM_W-1:0] zs;
    } t_smp;

endpackage

### rtl/gtex_in_if.sv
// Input channel: texel writes and block render beats.
// Depends on nothing; ADDR_BITS sets the texel address width.
interface gtex_in_if #(
    parameter int ADDR_BITS = 14
) ();
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [ADDR_BITS-1:0] texel_addr;
    logic [7:0]           texel_value;
    logic [15:0]          coord_top_left;
    logic [15:0]          coord_top_right;
    logic [15:0]          coord_bottom_left;
    logic [15:0]          coord_bottom_right;
    logic [7:0]           shade_top_left;
    logic [7:0]           shade_top_right;
    logic [7:0]           shade_bottom_left;
    logic [7:0]           shade_bottom_right;

    modport source (
        output valid, kind, texel_addr, texel_value,
               coord_top_left, coord_top_right, coord_bottom_left, coord_bottom_right,
               shade_top_left, shade_top_right, shade_bottom_left, shade_bottom_right,
        input  ready
    );
    modport sink (
        input  valid, kind, texel_addr, texel_value,
               coord_top_left, coord_top_right, coord_bottom_left, coord_bottom_right,
               shade_top_left, shade_top_right, shade_bottom_left, shade_bottom_right,
        output ready
    );
endinterface

### rtl/gtex_out_if.sv
// Output channel: one pixel per beat.
// Depends on nothing.
interface gtex_out_if ();
    logic       valid;
    logic       ready;
    logic [2:0] pixel_column;
    logic [2:0] pixel_row;
    logic [7:0] pixel_color;
    logic       last_pixel;

    modport source (
        output valid, pixel_column, pixel_row, pixel_color, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_column, pixel_row, pixel_color, last_pixel,
        output ready
    );
endinterface

### rtl/gtex_ram.sv
// Generic single-port RAM, registered read, read data held when disabled.
// No dependencies.
module gtex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/gtex_gen.sv
// Item sequencer: holds one input beat and steps a block over 32 pixels.
// Depends on gtex_pkg and gtex_in_if.
module gtex_gen (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    gtex_in_if.sink       i_in,
    output logic          o_valid,
    output gtex_pkg::t_item o_item
);
    typedef logic signed [gtex_pkg::DLT_W-1:0] t_dlt;
    typedef logic signed [gtex_pkg::ACC_W-1:0] t_acc;

    function automatic t_dlt f_delta(input logic [7:0] a, input logic [7:0] b);
        logic signed [8:0] diff;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        return diff[8:3];
    endfunction

    function automatic t_acc f_base(input logic [7:0] a, input t_dlt d);
        return t_acc'({2'b00, a}) + t_acc'(d);
    endfunction

    logic                              r_busy;
    gtex_pkg::t_kind                   r_kind;
    logic [2:0]                        r_x;
    logic [1:0]                        r_yi;
    logic [gtex_pkg::ADDR_MAX_W-1:0]   r_waddr;
    logic [7:0]                        r_wdata;
    t_dlt                              r_d_s1, r_d_s2, r_d_t1, r_d_t2, r_d_z1, r_d_z2;
    t_acc                              r_b_s1, r_b_s2, r_b_t1, r_b_t2, r_b_z1, r_b_z2;
    t_acc                              r_s1, r_s2, r_t1, r_t2, r_z1, r_z2;

    t_dlt  n_d_s1, n_d_s2, n_d_t1, n_d_t2, n_d_z1, n_d_z2;
    logic  w_last, w_emit, w_accept;

    assign w_last   = (r_kind == gtex_pkg::KIND_WRITE) ||
                      (r_x == gtex_pkg::LAST_COL && r_yi == gtex_pkg::LAST_ROW);
    assign w_emit   = r_busy && i_en;
    assign i_in.ready = !r_busy || (i_en && w_last);
    assign w_accept = i_in.valid && i_in.ready;

    always_comb begin
        n_d_s1 = f_delta(i_in.coord_top_left[15:8],    i_in.coord_top_right[15:8]);
        n_d_s2 = f_delta(i_in.coord_bottom_left[15:8], i_in.coord_bottom_right[15:8]);
        n_d_t1 = f_delta(i_in.coord_top_left[7:0],     i_in.coord_top_right[7:0]);
        n_d_t2 = f_delta(i_in.coord_bottom_left[7:0],  i_in.coord_bottom_right[7:0]);
        n_d_z1 = f_delta(i_in.shade_top_left,          i_in.shade_top_right);
        n_d_z2 = f_delta(i_in.shade_bottom_left,       i_in.shade_bottom_right);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_emit && w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= gtex_pkg::t_kind'(i_in.kind);
            r_x     <= '0;
            r_yi    <= '0;
            r_waddr <= gtex_pkg::ADDR_MAX_W'(i_in.texel_addr);
            r_wdata <= i_in.texel_value;
            r_d_s1  <= n_d_s1;
            r_d_s2  <= n_d_s2;
            r_d_t1  <= n_d_t1;
            r_d_t2  <= n_d_t2;
            r_d_z1  <= n_d_z1;
            r_d_z2  <= n_d_z2;
            r_b_s1  <= f_base(i_in.coord_top_left[15:8],    n_d_s1);
            r_b_s2  <= f_base(i_in.coord_bottom_left[15:8], n_d_s2);
            r_b_t1  <= f_base(i_in.coord_top_left[7:0],     n_d_t1);
            r_b_t2  <= f_base(i_in.coord_bottom_left[7:0],  n_d_t2);
            r_b_z1  <= f_base(i_in.shade_top_left,          n_d_z1);
            r_b_z2  <= f_base(i_in.shade_bottom_left,       n_d_z2);
            r_s1    <= f_base(i_in.coord_top_left[15:8],    n_d_s1);
            r_s2    <= f_base(i_in.coord_bottom_left[15:8], n_d_s2);
            r_t1    <= f_base(i_in.coord_top_left[7:0],     n_d_t1);
            r_t2    <= f_base(i_in.coord_bottom_left[7:0],  n_d_t2);
            r_z1    <= f_base(i_in.shade_top_left,          n_d_z1);
            r_z2    <= f_base(i_in.shade_bottom_left,       n_d_z2);
        end else if (w_emit) begin
            r_x <= r_x + 3'd1;
            if (r_x == gtex_pkg::LAST_COL) begin
                r_yi <= r_yi + 2'd1;
                r_s1 <= r_b_s1;
                r_s2 <= r_b_s2;
                r_t1 <= r_b_t1;
                r_t2 <= r_b_t2;
                r_z1 <= r_b_z1;
                r_z2 <= r_b_z2;
            end else begin
                r_s1 <= r_s1 + t_acc'(r_d_s1);
                r_s2 <= r_s2 + t_acc'(r_d_s2);
                r_t1 <= r_t1 + t_acc'(r_d_t1);
                r_t2 <= r_t2 + t_acc'(r_d_t2);
                r_z1 <= r_z1 + t_acc'(r_d_z1);
                r_z2 <= r_z2 + t_acc'(r_d_z2);
            end
        end
    end

    assign o_valid = r_busy;

    always_comb begin
        o_item.kind  = r_kind;
        o_item.x     = r_x;
        o_item.yi    = r_yi;
        o_item.last  = w_last;
        o_item.waddr = r_waddr;
        o_item.wdata = r_wdata;
        o_item.s1    = r_s1;
        o_item.s2    = r_s2;
        o_item.t1    = r_t1;
        o_item.t2    = r_t2;
        o_item.z1    = r_z1;
        o_item.z2    = r_z2;
    end
endmodule

### rtl/gtex_interp.sv
// Row interpolation: row deltas, then row-scaled sample of u, v and shade.
// Depends on gtex_pkg.
module gtex_interp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  gtex_pkg::t_item i_item,
    output logic            o_valid,
    output gtex_pkg::t_smp  o_smp
);
    localparam int DW = gtex_pkg::ACC_W + 1;
    localparam int SW = gtex_pkg::SUM_W;

    logic            r_v2, r_v3;
    gtex_pkg::t_mid  r_mid, n_mid;
    gtex_pkg::t_smp  r_smp, n_smp;

    logic signed [DW-1:0] w_ds, w_dt, w_dz;
    logic signed [SW-1:0] w_y, w_ys, w_yt, w_yz;

    always_comb begin
        w_ds = DW'(i_item.s2) - DW'(i_item.s1);
        w_dt = DW'(i_item.t2) - DW'(i_item.t1);
        w_dz = DW'(i_item.z2) - DW'(i_item.z1);
        n_mid.kind  = i_item.kind;
        n_mid.x     = i_item.x;
        n_mid.yi    = i_item.yi;
        n_mid.last  = i_item.last;
        n_mid.waddr = i_item.waddr;
        n_mid.wdata = i_item.wdata;
        n_mid.s1    = i_item.s1;
        n_mid.t1    = i_item.t1;
        n_mid.z1    = i_item.z1;
        n_mid.ds    = w_ds[DW-1:3];
        n_mid.dt    = w_dt[DW-1:3];
        n_mid.dz    = w_dz[DW-1:3];
    end

    always_comb begin
        w_y  = SW'($signed({1'b0, r_mid.yi, 1'b0}));
        w_ys = w_y * SW'(r_mid.ds);
        w_yt = w_y * SW'(r_mid.dt);
        w_yz = w_y * SW'(r_mid.dz);
        n_smp.kind  = r_mid.kind;
        n_smp.x     = r_mid.x;
        n_smp.yi    = r_mid.yi;
        n_smp.last  = r_mid.last;
        n_smp.waddr = r_mid.waddr;
        n_smp.wdata = r_mid.wdata;
        n_smp.u     = SW'(r_mid.s1) + w_ys;
        n_smp.v     = SW'(r_mid.t1) + w_yt;
        n_smp.zs    = SW'(r_mid.z1) + w_yz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid <= n_mid;
            r_smp <= n_smp;
        end
    end

    assign o_valid = r_v3;
    assign o_smp   = r_smp;
endmodule

### rtl/grid_block_texture_interpolator.sv
// Top level: sequencer, row interpolation, texture RAM and pixel output register.
// Depends on gtex_pkg, gtex_in_if, gtex_out_if, gtex_ram, gtex_gen, gtex_interp.
//
//   port   | dir | beat
//   -------+-----+------------------------------------------------------
//   i_in   | in  | texel write (kind 0) or block render with 4 corners
//   o_pix  | out | one pixel: column, even row, color, last of block
//
// An accepted beat passes the sequencer, row delta, sample, RAM read and output
// registers to o_pix. A block is 32 pixels, one pixel a cycle while o_pix does
// not stall, set by the single texture RAM port; a texel write is one step. The
// next beat is taken on the cycle the previous one issues its last step.
// Reset clears only valid and busy flags; texture contents are undefined.
// A stall on o_pix freezes every stage and the RAM read register together.
module grid_block_texture_interpolator #(
    parameter int TEX_ROW_LOG2  = 7,
    parameter int TEX_ADDR_BITS = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gtex_in_if.sink    i_in,
    gtex_out_if.source o_pix
);
    localparam int EXT_W = (TEX_ADDR_BITS > gtex_pkg::SUM_W) ? TEX_ADDR_BITS
                                                              : gtex_pkg::SUM_W;

    logic                     w_en;
    logic                     w_gen_valid;
    gtex_pkg::t_item          w_gen_item;
    logic                     w_smp_valid;
    gtex_pkg::t_smp           w_smp;
    logic signed [EXT_W-1:0]  w_u_ext, w_v_ext;
    logic [TEX_ADDR_BITS-1:0] w_pix_addr, w_addr;
    logic                     w_we;
    logic [7:0]               w_rdata;

    logic       r_v4;
    logic [2:0] r_x4;
    logic [1:0] r_yi4;
    logic       r_last4;
    logic [2:0] r_z4;
    logic       r_out_valid;
    logic [2:0] r_out_col;
    logic [2:0] r_out_row;
    logic [7:0] r_out_color;
    logic       r_out_last;

    assign w_en = !r_out_valid || o_pix.ready;

    gtex_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_in    (i_in),
        .o_valid (w_gen_valid),
        .o_item  (w_gen_item)
    );

    gtex_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_gen_valid),
        .i_item  (w_gen_item),
        .o_valid (w_smp_valid),
        .o_smp   (w_smp)
    );

    always_comb begin
        w_u_ext    = EXT_W'(w_smp.u);
        w_v_ext    = EXT_W'(w_smp.v);
        w_pix_addr = TEX_ADDR_BITS'((w_v_ext <<< TEX_ROW_LOG2) + w_u_ext);
        w_we       = w_smp_valid && (w_smp.kind == gtex_pkg::KIND_WRITE);
        w_addr     = w_we ? TEX_ADDR_BITS'(w_smp.waddr) : w_pix_addr;
    end

    gtex_ram #(
        .WIDTH(8),
        .DEPTH(1 << TEX_ADDR_BITS)
    ) u_tex (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_smp.wdata),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4        <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_v4        <= w_smp_valid && (w_smp.kind == gtex_pkg::KIND_BLOCK);
            r_out_valid <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x4        <= w_smp.x;
            r_yi4       <= w_smp.yi;
            r_last4     <= w_smp.last;
            r_z4        <= w_smp.zs[7:5];
            r_out_col   <= r_x4;
            r_out_row   <= {r_yi4, 1'b0};
            r_out_color <= w_rdata - gtex_pkg::TEXEL_BIAS + {r_z4, 5'b00000};
            r_out_last  <= r_last4;
        end
    end

    assign o_pix.valid        = r_out_valid;
    assign o_pix.pixel_column = r_out_col;
    assign o_pix.pixel_row    = r_out_row;
    assign o_pix.pixel_color  = r_out_color;
    assign o_pix.last_pixel   = r_out_last;

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_gen_valid |-> i_in.ready)
        else $error("sequencer idle but input not ready");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gen_valid && !w_en |=> $stable(w_gen_item.x) && $stable(w_gen_item.yi))
        else $error("sequencer stepped during stall");

    a_col_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pix.valid && o_pix.ready && (o_pix.pixel_column != gtex_pkg::LAST_COL)
        |=> !o_pix.valid || (o_pix.pixel_column == $past(o_pix.pixel_column) + 3'd1))
        else $error("pixel column out of order");

    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 && r_last4 |-> (r_x4 == gtex_pkg::LAST_COL) && (r_yi4 == gtex_pkg::LAST_ROW))
        else $error("last pixel flag off the final block position");
endmodule

### test/grid_block_texture_interpolator_tb.sv
// Testbench for grid_block_texture_interpolator: preloads the texture, then runs
// directed and random texel writes and block renders, checking every pixel beat.
// Depends on gtex_pkg, gtex_in_if, gtex_out_if and the RTL top level.
module grid_block_texture_interpolator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_LOG2     = 7;
    localparam int ADDR_BITS    = 14;
    localparam int TEX_DEPTH    = 1 << ADDR_BITS;
    localparam int TEXEL_OFFSET = 224;
    localparam int RANDOM_ITEMS = 130;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 500000;

    typedef struct packed {
        gtex_pkg::t_kind        kind;
        logic [ADDR_BITS-1:0]   texel_addr;
        logic [7:0]             texel_value;
        logic [15:0]            coord_tl;
        logic [15:0]            coord_tr;
        logic [15:0]            coord_bl;
        logic [15:0]            coord_br;
        logic [7:0]             shade_tl;
        logic [7:0]             shade_tr;
        logic [7:0]             shade_bl;
        logic [7:0]             shade_br;
    } beat_t;

    typedef struct packed {
        logic [2:0] column;
        logic [2:0] row;
        logic [7:0] color;
        logic       last;
    } pixel_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    gtex_in_if #(.ADDR_BITS(ADDR_BITS)) beat_ch ();
    gtex_out_if                         pixel_ch ();

    grid_block_texture_interpolator #(
        .TEX_ROW_LOG2 (ROW_LOG2),
        .TEX_ADDR_BITS(ADDR_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (beat_ch),
        .o_pix  (pixel_ch)
    );

    logic [7:0] texture_copy [TEX_DEPTH];
    pixel_t     pending_pixels [$];
    int         mismatches  = 0;
    bit         sender_gaps = 1'b0;
    int         burst_left  = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("grid_block_texture_interpolator verification failed");
        $finish;
    end

    // receiver: rotates through always-ready, random, periodic and long-stall modes
    initial begin : pixel_sink
        int tick;
        int hold;
        tick = 0;
        hold = 0;
        pixel_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            tick++;
            case ((tick / 300) % 4)
                0: pixel_ch.ready = 1'b1;
                1: pixel_ch.ready = ($urandom_range(0, 3) != 0);
                2: pixel_ch.ready = ((tick % 11) < 6);
                default: begin
                    if (hold > 0) begin
                        hold--;
                        pixel_ch.ready = 1'b0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        hold = int'($urandom_range(1, 12));
                        pixel_ch.ready = 1'b0;
                    end else begin
                        pixel_ch.ready = 1'b1;
                    end
                end
            endcase
        end
    end

    function automatic void predict_block_pixels(
        input logic [15:0] c_tl, input logic [15:0] c_tr,
        input logic [15:0] c_bl, input logic [15:0] c_br,
        input logic [7:0]  s_tl, input logic [7:0]  s_tr,
        input logic [7:0]  s_bl, input logic [7:0]  s_br
    );
        int ua, va, ub, vb, uc, vc, ud, vd, sa, sb, sc, sd;
        int du1, du2, dv1, dv2, dz1, dz2;
        int k, s1, s2, t1, t2, z1, z2, u, v, z, addr, color;
        pixel_t p;
        ua = int'(c_tl[15:8]);  va = int'(c_tl[7:0]);
        ub = int'(c_tr[15:8]);  vb = int'(c_tr[7:0]);
        uc = int'(c_bl[15:8]);  vc = int'(c_bl[7:0]);
        ud = int'(c_br[15:8]);  vd = int'(c_br[7:0]);
        sa = int'(s_tl);  sb = int'(s_tr);  sc = int'(s_bl);  sd = int'(s_br);
        du1 = (ub - ua) >>> 3;
        du2 = (ud - uc) >>> 3;
        dv1 = (vb - va) >>> 3;
        dv2 = (vd - vc) >>> 3;
        dz1 = (sb - sa) >>> 3;
        dz2 = (sd - sc) >>> 3;
        for (int y = 0; y < 8; y += 2) begin
            for (int x = 0; x < 8; x++) begin
                // column step applied before the first sample
                k  = x + 1;
                s1 = ua + k * du1;
                s2 = uc + k * du2;
                t1 = va + k * dv1;
                t2 = vc + k * dv2;
                z1 = sa + k * dz1;
                z2 = sc + k * dz2;
                u  = s1 + y * ((s2 - s1) >>> 3);
                v  = t1 + y * ((t2 - t1) >>> 3);
                z  = (z1 + y * ((z2 - z1) >>> 3)) >>> 5;
                addr  = ((v << ROW_LOG2) + u) & (TEX_DEPTH - 1);
                color = int'(texture_copy[addr]) - TEXEL_OFFSET + z * 32;
                p.column = x[2:0];
                p.row    = y[2:0];
                p.color  = color[7:0];
                p.last   = (x == 7 && y == 6);
                pending_pixels.push_back(p);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && beat_ch.valid && beat_ch.ready) begin
            if (beat_ch.kind == gtex_pkg::KIND_WRITE) begin
                texture_copy[beat_ch.texel_addr] = beat_ch.texel_value;
            end else begin
                predict_block_pixels(beat_ch.coord_top_left, beat_ch.coord_top_right,
                                     beat_ch.coord_bottom_left, beat_ch.coord_bottom_right,
                                     beat_ch.shade_top_left, beat_ch.shade_top_right,
                                     beat_ch.shade_bottom_left, beat_ch.shade_bottom_right);
            end
        end
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin : check_pixel
        pixel_t got;
        pixel_t want;
        if (i_rst_n && pixel_ch.valid && pixel_ch.ready) begin
            got = {pixel_ch.pixel_column, pixel_ch.pixel_row,
                   pixel_ch.pixel_color, pixel_ch.last_pixel};
            if (pending_pixels.size() == 0) begin
                note_mismatch($sformatf("unexpected pixel: col %0d row %0d color %0d last %0b",
                                        got.column, got.row, got.color, got.last));
            end else begin
                want = pending_pixels.pop_front();
                if (got.column !== want.column || got.row !== want.row ||
                    got.color !== want.color || got.last !== want.last) begin
                    note_mismatch($sformatf(
                        "pixel mismatch: exp col %0d row %0d color %0d last %0b, %s",
                        want.column, want.row, want.color, want.last,
                        $sformatf("got col %0d row %0d color %0d last %0b",
                                  got.column, got.row, got.color, got.last)));
                end
            end
        end
    end

    function automatic beat_t texel_write(input logic [ADDR_BITS-1:0] addr,
                                          input logic [7:0] value);
        beat_t b;
        b.kind        = gtex_pkg::KIND_WRITE;
        b.texel_addr  = addr;
        b.texel_value = value;
        b.coord_tl    = 16'($urandom);
        b.coord_tr    = 16'($urandom);
        b.coord_bl    = 16'($urandom);
        b.coord_br    = 16'($urandom);
        b.shade_tl    = 8'($urandom);
        b.shade_tr    = 8'($urandom);
        b.shade_bl    = 8'($urandom);
        b.shade_br    = 8'($urandom);
        return b;
    endfunction

    function automatic beat_t block_beat(
        input logic [15:0] c_tl, input logic [15:0] c_tr,
        input logic [15:0] c_bl, input logic [15:0] c_br,
        input logic [7:0]  s_tl, input logic [7:0]  s_tr,
        input logic [7:0]  s_bl, input logic [7:0]  s_br
    );
        beat_t b;
        b.kind        = gtex_pkg::KIND_BLOCK;
        b.texel_addr  = ADDR_BITS'($urandom);
        b.texel_value = 8'($urandom);
        b.coord_tl    = c_tl;
        b.coord_tr    = c_tr;
        b.coord_bl    = c_bl;
        b.coord_br    = c_br;
        b.shade_tl    = s_tl;
        b.shade_tr    = s_tr;
        b.shade_bl    = s_bl;
        b.shade_br    = s_br;
        return b;
    endfunction

    function automatic beat_t random_block();
        logic [7:0]  u0, v0, cu, cv, ru, rv, lvl;
        logic [15:0] tl, tr, bl, br;
        logic [7:0]  sh [4];
        if ($urandom_range(0, 3) == 0) begin
            tl = 16'($urandom);
            tr = 16'($urandom);
            bl = 16'($urandom);
            br = 16'($urandom);
        end else begin
            // neighboring corners, as a grid raycast would give
            u0 = 8'($urandom);
            v0 = 8'($urandom);
            cu = 8'($urandom_range(0, 48) - 24);
            cv = 8'($urandom_range(0, 48) - 24);
            ru = 8'($urandom_range(0, 48) - 24);
            rv = 8'($urandom_range(0, 48) - 24);
            tl = {u0, v0};
            tr = {u0 + cu, v0 + cv};
            bl = {u0 + ru, v0 + rv};
            br = {u0 + cu + ru, v0 + cv + rv};
        end
        for (int i = 0; i < 4; i++) begin
            lvl   = 8'($urandom);
            sh[i] = ($urandom_range(0, 1) == 0) ? {lvl[2:0], 5'd0} : lvl;
        end
        return block_beat(tl, tr, bl, br, sh[0], sh[1], sh[2], sh[3]);
    endfunction

    task automatic send_beat(input beat_t b);
        int idle_cycles;
        if (sender_gaps) begin
            if (burst_left == 0) begin
                idle_cycles = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40)
                                                          : $urandom_range(1, 6);
                burst_left  = $urandom_range(1, 8);
                repeat (idle_cycles) begin
                    @(negedge i_clk);
                    beat_ch.valid = 1'b0;
                end
            end
            burst_left--;
        end
        @(negedge i_clk);
        beat_ch.valid              = 1'b1;
        beat_ch.kind               = b.kind;
        beat_ch.texel_addr         = b.texel_addr;
        beat_ch.texel_value        = b.texel_value;
        beat_ch.coord_top_left     = b.coord_tl;
        beat_ch.coord_top_right    = b.coord_tr;
        beat_ch.coord_bottom_left  = b.coord_bl;
        beat_ch.coord_bottom_right = b.coord_br;
        beat_ch.shade_top_left     = b.shade_tl;
        beat_ch.shade_top_right    = b.shade_tr;
        beat_ch.shade_bottom_left  = b.shade_bl;
        beat_ch.shade_bottom_right = b.shade_br;
        do @(posedge i_clk); while (!beat_ch.ready);
    endtask

    // every texel gets written so no render ever reads an unwritten entry
    task automatic preload_texture();
        sender_gaps = 1'b0;
        for (int a = 0; a < TEX_DEPTH; a++) begin
            send_beat(texel_write(a[ADDR_BITS-1:0], 8'($urandom)));
        end
    endtask

    task automatic test_texel_write_extremes();
        sender_gaps = 1'b1;
        send_beat(texel_write('0, 8'h00));
        send_beat(texel_write('1, 8'hFF));
        send_beat(block_beat(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                             8'h00, 8'h00, 8'h00, 8'h00));
        send_beat(block_beat(16'h7F7F, 16'h7F7F, 16'h7F7F, 16'h7F7F,
                             8'hFF, 8'hFF, 8'hFF, 8'hFF));
    endtask

    task automatic test_coord_extremes();
        sender_gaps = 1'b0;
        send_beat(block_beat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
        send_beat(block_beat(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                             8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
        send_beat(block_beat(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF,
                             8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
        // descending corners drive the interpolants negative; the address wraps
        send_beat(block_beat(16'h0101, 16'h0000, 16'h0101, 16'h0000,
                             8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
        send_beat(block_beat(16'h00FF, 16'hFF00, 16'hFF00, 16'h00FF,
                             8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
    endtask

    task automatic test_shade_extremes();
        sender_gaps = 1'b1;
        // shade sum below zero
        send_beat(block_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             8'h01, 8'h00, 8'h01, 8'h00));
        send_beat(block_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             8'hFF, 8'h00, 8'h00, 8'hFF));
        send_beat(block_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             8'h00, 8'hFF, 8'hFF, 8'h00));
        send_beat(block_beat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             8'h00, 8'h00, 8'hFF, 8'hFF));
    endtask

    task automatic test_write_then_read();
        logic [15:0]          c;
        logic [ADDR_BITS-1:0] addr;
        sender_gaps = 1'b0;
        c    = 16'($urandom);
        addr = ADDR_BITS'((int'(c[7:0]) << ROW_LOG2) + int'(c[15:8]));
        send_beat(texel_write(addr, 8'($urandom)));
        send_beat(block_beat(c, c, c, c,
                             8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
        send_beat(texel_write(addr, 8'($urandom)));
        send_beat(block_beat(c, c, c, c,
                             8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 20 == 0) begin
                sender_gaps = ($urandom_range(0, 2) != 0);
            end
            if ($urandom_range(0, 9) < 3) begin
                send_beat(texel_write(ADDR_BITS'($urandom), 8'($urandom)));
            end else begin
                send_beat(random_block());
            end
        end
    endtask

    initial begin
        beat_ch.valid              = 1'b0;
        beat_ch.kind               = gtex_pkg::KIND_WRITE;
        beat_ch.texel_addr         = '0;
        beat_ch.texel_value        = '0;
        beat_ch.coord_top_left     = '0;
        beat_ch.coord_top_right    = '0;
        beat_ch.coord_bottom_left  = '0;
        beat_ch.coord_bottom_right = '0;
        beat_ch.shade_top_left     = '0;
        beat_ch.shade_top_right    = '0;
        beat_ch.shade_bottom_left  = '0;
        beat_ch.shade_bottom_right = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        preload_texture();
        test_texel_write_extremes();
        test_coord_extremes();
        test_shade_extremes();
        test_write_then_read();
        test_random_traffic();

        @(negedge i_clk);
        beat_ch.valid = 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("grid_block_texture_interpolator verification clean");
        end else begin
            $display("grid_block_texture_interpolator verification failed");
        end
        $finish;
    end

endmodule

### grid_block_texture_interpolator.f
rtl/gtex_pkg.sv
rtl/gtex_in_if.sv
rtl/gtex_out_if.sv
rtl/gtex_ram.sv
rtl/gtex_gen.sv
rtl/gtex_interp.sv
rtl/grid_block_texture_interpolator.sv
test/grid_block_texture_interpolator_tb.sv
